// File: rtl/crp_pkg.sv
// Shared widths, register indexes and constants for the contrast recolor pixel core.
package crp_pkg;

    localparam int ChanWidth     = 8;
    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 8;

    typedef logic [ChanWidth-1:0]     chan_t;
    typedef logic [CfgIndexWidth-1:0] cfg_index_t;
    typedef logic [CfgDataWidth-1:0]  cfg_data_t;

    localparam cfg_index_t RegBgLuma            = 2'd0;
    localparam cfg_index_t RegContrastThreshold = 2'd1;
    localparam cfg_index_t RegMinMargin         = 2'd2;
    localparam cfg_index_t RegPushOffset        = 2'd3;

    localparam chan_t ResetBgLuma            = 8'd45;
    localparam chan_t ResetContrastThreshold = 8'd100;
    localparam chan_t ResetMinMargin         = 8'd80;
    localparam chan_t ResetPushOffset        = 8'd120;

    localparam int SumWidth = 18;
    typedef logic [SumWidth-1:0] sum_t;

    localparam sum_t WeightRed   = 18'd299;
    localparam sum_t WeightGreen = 18'd587;
    localparam sum_t WeightBlue  = 18'd114;

    // floor(sum / 1000) == (sum * ceil(2^30 / 1000)) >> 30 for every sum below 2^18
    localparam int RecipWidth = 21;
    localparam int RecipShift = 30;
    localparam logic [RecipWidth-1:0] RecipLuma = 21'd1073742;
    localparam int ProdWidth = SumWidth + RecipWidth;

endpackage

// File: rtl/crp_pixel_in_if.sv
// Input color request channel.
interface crp_pixel_in_if;
    logic           valid;
    logic           ready;
    crp_pkg::chan_t in_red;
    crp_pkg::chan_t in_green;
    crp_pkg::chan_t in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue, input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

// File: rtl/crp_pixel_out_if.sv
// Result color request channel.
interface crp_pixel_out_if;
    logic           valid;
    logic           ready;
    crp_pkg::chan_t out_red;
    crp_pkg::chan_t out_green;
    crp_pkg::chan_t out_blue;
    logic           was_adjusted;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output was_adjusted, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input was_adjusted, output ready);
endinterface

// File: rtl/crp_cfg_if.sv
// Configuration register write channel.
interface crp_cfg_if;
    logic                  valid;
    logic                  ready;
    crp_pkg::cfg_index_t   reg_index;
    crp_pkg::cfg_data_t    data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

// File: rtl/contrast_recolor_pixel_core.sv
// Contrast recolor pixel core: four-stage pipeline that recolors low-contrast pixels.
// A request accepted into stage 1 moves on through stages 2, 3 and 4 to the output.
// Throughput: one pixel per cycle; each stage holds only while its successor is full.
// The weighted sum, the reciprocal multiply, the target select and the channel clamp
// take one stage each.
// Reset clears all stage valid bits and loads the register defaults 45, 100, 80, 120.
module contrast_recolor_pixel_core
(
    input  logic                    clk,
    input  logic                    rst_n,
    crp_pixel_in_if.sink            pixel_in,
    crp_pixel_out_if.source         pixel_out,
    crp_cfg_if.sink                 cfg
);

    crp_pkg::chan_t bg_luma_reg;
    crp_pkg::chan_t threshold_reg;
    crp_pkg::chan_t min_margin_reg;
    crp_pkg::chan_t push_offset_reg;

    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    crp_pkg::chan_t r1_reg, g1_reg, b1_reg;
    crp_pkg::sum_t  sum1_reg;
    crp_pkg::chan_t r2_reg, g2_reg, b2_reg;
    crp_pkg::chan_t luma2_reg;
    crp_pkg::chan_t r3_reg, g3_reg, b3_reg;
    logic signed [8:0] diff3_reg;
    logic              adj3_reg;
    crp_pkg::chan_t r4_reg, g4_reg, b4_reg;
    logic              adj4_reg;

    crp_pkg::sum_t                      sum1_next;
    logic [crp_pkg::ProdWidth-1:0]      prod2;
    crp_pkg::chan_t                     luma2_next;
    crp_pkg::chan_t                     contrast;
    crp_pkg::chan_t                     inv_luma;
    logic [8:0]                         bg_plus_margin;
    logic [8:0]                         bg_plus_push;
    logic                               near_bg;
    crp_pkg::chan_t                     target;
    logic                               adj3_next;
    logic signed [8:0]                  diff3_next;

    function automatic crp_pkg::chan_t clamp_add(crp_pkg::chan_t ch, logic signed [8:0] d);
        logic signed [9:0] s;
        s = $signed({2'b00, ch}) + {d[8], d};
        if (s[9])
            clamp_add = 8'd0;
        else if (s[8])
            clamp_add = 8'hFF;
        else
            clamp_add = s[7:0];
    endfunction

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_luma_reg     <= crp_pkg::ResetBgLuma;
            threshold_reg   <= crp_pkg::ResetContrastThreshold;
            min_margin_reg  <= crp_pkg::ResetMinMargin;
            push_offset_reg <= crp_pkg::ResetPushOffset;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                crp_pkg::RegBgLuma:            bg_luma_reg     <= cfg.data;
                crp_pkg::RegContrastThreshold: threshold_reg   <= cfg.data;
                crp_pkg::RegMinMargin:         min_margin_reg  <= cfg.data;
                crp_pkg::RegPushOffset:        push_offset_reg <= cfg.data;
                default:                       bg_luma_reg     <= bg_luma_reg;
            endcase
        end
    end

    assign en4 = !v4_reg || pixel_out.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pixel_in.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= pixel_in.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    assign sum1_next = {10'd0, pixel_in.in_red}   * crp_pkg::WeightRed
                     + {10'd0, pixel_in.in_green} * crp_pkg::WeightGreen
                     + {10'd0, pixel_in.in_blue}  * crp_pkg::WeightBlue;

    assign prod2      = {{crp_pkg::RecipWidth{1'b0}}, sum1_reg}
                      * {{crp_pkg::SumWidth{1'b0}}, crp_pkg::RecipLuma};
    assign luma2_next = prod2[crp_pkg::RecipShift +: crp_pkg::ChanWidth];

    always_comb
    begin
        contrast       = (luma2_reg >= bg_luma_reg) ? (luma2_reg - bg_luma_reg)
                                                    : (bg_luma_reg - luma2_reg);
        adj3_next      = contrast < threshold_reg;
        inv_luma       = ~luma2_reg;
        bg_plus_margin = {1'b0, bg_luma_reg} + {1'b0, min_margin_reg};
        bg_plus_push   = {1'b0, bg_luma_reg} + {1'b0, push_offset_reg};
        if (!bg_luma_reg[7])
        begin
            near_bg = {1'b0, inv_luma} < bg_plus_margin;
            target  = near_bg ? (bg_plus_push[8] ? 8'hFF : bg_plus_push[7:0]) : inv_luma;
        end
        else
        begin
            near_bg = (bg_luma_reg < min_margin_reg)
                   || (inv_luma > (bg_luma_reg - min_margin_reg));
            target  = near_bg ? ((bg_luma_reg < push_offset_reg) ? 8'd0
                                                                 : bg_luma_reg - push_offset_reg)
                              : inv_luma;
        end
        diff3_next = adj3_next ? ($signed({1'b0, target}) - $signed({1'b0, luma2_reg}))
                               : 9'sd0;
    end

    always_ff @(posedge clk)
    begin
        if (en1 && pixel_in.valid)
        begin
            r1_reg   <= pixel_in.in_red;
            g1_reg   <= pixel_in.in_green;
            b1_reg   <= pixel_in.in_blue;
            sum1_reg <= sum1_next;
        end
        if (en2 && v1_reg)
        begin
            r2_reg    <= r1_reg;
            g2_reg    <= g1_reg;
            b2_reg    <= b1_reg;
            luma2_reg <= luma2_next;
        end
        if (en3 && v2_reg)
        begin
            r3_reg    <= r2_reg;
            g3_reg    <= g2_reg;
            b3_reg    <= b2_reg;
            diff3_reg <= diff3_next;
            adj3_reg  <= adj3_next;
        end
        if (en4 && v3_reg)
        begin
            r4_reg   <= clamp_add(r3_reg, diff3_reg);
            g4_reg   <= clamp_add(g3_reg, diff3_reg);
            b4_reg   <= clamp_add(b3_reg, diff3_reg);
            adj4_reg <= adj3_reg;
        end
    end

    assign pixel_out.valid        = v4_reg;
    assign pixel_out.out_red      = r4_reg;
    assign pixel_out.out_green    = g4_reg;
    assign pixel_out.out_blue     = b4_reg;
    assign pixel_out.was_adjusted = adj4_reg;

endmodule
